/* rtl/core/serial_motion_sensor_port_top_assert.svh */
// assertion helpers for the motion sensor port
`ifndef SERIAL_MOTION_SENSOR_PORT_TOP_ASSERT_SVH
`define SERIAL_MOTION_SENSOR_PORT_TOP_ASSERT_SVH

// same-cycle implication
`define SMSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/smsp_pkg.sv */
`default_nettype none
package smsp_pkg;

  localparam int unsigned REGISTER_COUNT_DEF = 18;

  localparam logic [7:0] REG_STATUS   = 8'h02;
  localparam logic [7:0] REG_DX       = 8'h03;
  localparam logic [7:0] REG_DY       = 8'h04;
  localparam logic [7:0] REG_CONFIG   = 8'h0A;
  localparam logic [7:0] REG_FRAME_LO = 8'h10;
  localparam logic [7:0] REG_FRAME_HI = 8'h11;

  localparam logic [7:0] FRAME_LO_RST = 8'h20;
  localparam logic [7:0] FRAME_HI_RST = 8'hD1;
  localparam logic [7:0] MOTION_FLAG  = 8'h80;
  localparam logic [7:0] ADDR_MASK    = 8'h7F;
  localparam logic [3:0] BYTE_BITS    = 4'd8;

  typedef enum logic [1:0] {
    PH_ADDR  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  typedef struct packed {
    logic              mode;
    logic              sclk;
    logic              sdata;
    logic              rumble;
    logic signed [7:0] motion_x;
    logic signed [7:0] motion_y;
  } step_t;

  typedef struct packed {
    logic serial_out;
    logic rumble_level;
  } result_t;

  function automatic logic [7:0] init_reg(input logic [6:0] a);
    logic [7:0] v;
    case (a)
      7'd0:    v = 8'h03;
      7'd1:    v = 8'h20;
      7'd5:    v = 8'h80;
      7'd6:    v = 8'h20;
      7'd7:    v = 8'h3F;
      7'd14:   v = 8'h64;
      7'd16:   v = 8'h20;
      7'd17:   v = 8'hD1;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/smsp_ram.sv */
`default_nettype none
module smsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 18,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/smsp_core.sv */
`default_nettype none
module smsp_core #(
  parameter int unsigned REGISTER_COUNT = smsp_pkg::REGISTER_COUNT_DEF,
  localparam int unsigned AW = $clog2(REGISTER_COUNT)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_valid_i,
  input  wire smsp_pkg::step_t   step_i,
  output smsp_pkg::result_t      res_o
);

  smsp_pkg::phase_e phase_q, phase_d;
  logic [3:0] bc_q, bc_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] wshift_q, wshift_d;
  logic       last_clk_q, last_clk_d;
  logic       out_bit_q, out_bit_d;
  logic       rumble_q, rumble_d;
  logic [7:0] pdx_q, pdx_d, pdy_q, pdy_d;
  logic [7:0] status_q, status_d, dx_q, dx_d, dy_q, dy_d;
  logic [7:0] config_q, config_d, frame_lo_q, frame_lo_d, frame_hi_q, frame_hi_d;
  logic [REGISTER_COUNT-1:0] valid_q, valid_d;

  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] idx;
  logic          in_range;
  logic          rising, low_low;
  logic [7:0]    rd_byte;

  assign idx      = addr_q[AW-1:0];
  assign in_range = addr_q < 8'(REGISTER_COUNT);
  assign rising   = !last_clk_q && step_i.sclk;
  assign low_low  = !last_clk_q && !step_i.sclk;

  smsp_ram #(
    .WIDTH (8),
    .DEPTH (REGISTER_COUNT)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (wshift_q),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (addr_q == smsp_pkg::REG_STATUS) begin
      rd_byte = status_q;
    end else if (addr_q == smsp_pkg::REG_DX) begin
      rd_byte = dx_q;
    end else if (addr_q == smsp_pkg::REG_DY) begin
      rd_byte = dy_q;
    end else if (addr_q == smsp_pkg::REG_CONFIG) begin
      rd_byte = config_q;
    end else if (addr_q == smsp_pkg::REG_FRAME_LO) begin
      rd_byte = frame_lo_q;
    end else if (addr_q == smsp_pkg::REG_FRAME_HI) begin
      rd_byte = frame_hi_q;
    end else if (!in_range) begin
      rd_byte = '0;
    end else if (valid_q[idx]) begin
      rd_byte = ram_rdata;
    end else begin
      rd_byte = smsp_pkg::init_reg(addr_q[6:0]);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    bc_d       = bc_q;
    addr_d     = addr_q;
    wshift_d   = wshift_q;
    last_clk_d = last_clk_q;
    out_bit_d  = out_bit_q;
    rumble_d   = rumble_q;
    pdx_d      = pdx_q;
    pdy_d      = pdy_q;
    status_d   = status_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    config_d   = config_q;
    frame_lo_d = frame_lo_q;
    frame_hi_d = frame_hi_q;
    valid_d    = valid_q;
    ram_we     = 1'b0;

    if (step_valid_i && step_i.mode) begin
      pdx_d = step_i.motion_x;
      pdy_d = step_i.motion_y;
    end else if (step_valid_i) begin
      rumble_d = step_i.rumble;
      case (phase_q)
        smsp_pkg::PH_ADDR: begin
          if (rising && bc_q < smsp_pkg::BYTE_BITS) begin
            addr_d = {addr_q[6:0], step_i.sdata};
            bc_d   = bc_q + 4'd1;
          end else if (bc_q == smsp_pkg::BYTE_BITS) begin
            if (addr_q[7]) begin
              phase_d  = smsp_pkg::PH_WRITE;
              addr_d   = addr_q & smsp_pkg::ADDR_MASK;
              wshift_d = '0;
            end else begin
              phase_d = smsp_pkg::PH_READ;
              if (addr_q == smsp_pkg::REG_STATUS) begin
                if (pdx_q != '0 || pdy_q != '0) begin
                  status_d = status_q | smsp_pkg::MOTION_FLAG;
                end
                dx_d  = pdx_q;
                dy_d  = pdy_q;
                pdx_d = '0;
                pdy_d = '0;
              end
            end
            bc_d = '0;
          end
        end
        smsp_pkg::PH_WRITE: begin
          if (rising && bc_q < smsp_pkg::BYTE_BITS) begin
            wshift_d = {wshift_q[6:0], step_i.sdata};
            bc_d     = bc_q + 4'd1;
          end else if (low_low && bc_q == smsp_pkg::BYTE_BITS) begin
            phase_d = smsp_pkg::PH_ADDR;
            bc_d    = '0;
            if (in_range) begin
              ram_we       = 1'b1;
              valid_d[idx] = 1'b1;
              if (addr_q == smsp_pkg::REG_STATUS)   status_d   = wshift_q;
              if (addr_q == smsp_pkg::REG_DX)       dx_d       = wshift_q;
              if (addr_q == smsp_pkg::REG_DY)       dy_d       = wshift_q;
              if (addr_q == smsp_pkg::REG_CONFIG)   config_d   = wshift_q;
              if (addr_q == smsp_pkg::REG_FRAME_LO) frame_lo_d = wshift_q;
              if (addr_q == smsp_pkg::REG_FRAME_HI) frame_hi_d = wshift_q;
            end
          end
        end
        smsp_pkg::PH_READ: begin
          if (rising && bc_q < smsp_pkg::BYTE_BITS) begin
            out_bit_d = rd_byte[~bc_q[2:0]];
            bc_d      = bc_q + 4'd1;
          end else if (low_low && bc_q == smsp_pkg::BYTE_BITS) begin
            phase_d = smsp_pkg::PH_ADDR;
            bc_d    = '0;
            if (addr_q == smsp_pkg::REG_STATUS) status_d = status_q & smsp_pkg::ADDR_MASK;
            if (addr_q == smsp_pkg::REG_DX)     dx_d     = '0;
            if (addr_q == smsp_pkg::REG_DY)     dy_d     = '0;
          end
        end
        default: begin
        end
      endcase
      last_clk_d = step_i.sclk;

      // config bit 7 forces a partial reset
      if (config_d[7]) begin
        pdx_d      = '0;
        pdy_d      = '0;
        rumble_d   = 1'b0;
        phase_d    = smsp_pkg::PH_ADDR;
        bc_d       = '0;
        addr_d     = '0;
        wshift_d   = '0;
        last_clk_d = 1'b0;
        out_bit_d  = 1'b0;
        status_d   = '0;
        dx_d       = '0;
        dy_d       = '0;
        config_d   = '0;
        frame_lo_d = smsp_pkg::FRAME_LO_RST;
        frame_hi_d = smsp_pkg::FRAME_HI_RST;
      end
    end

    res_o.serial_out   = out_bit_d;
    res_o.rumble_level = rumble_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= smsp_pkg::PH_ADDR;
      bc_q       <= '0;
      addr_q     <= '0;
      wshift_q   <= '0;
      last_clk_q <= 1'b0;
      out_bit_q  <= 1'b0;
      rumble_q   <= 1'b0;
      pdx_q      <= '0;
      pdy_q      <= '0;
      status_q   <= '0;
      dx_q       <= '0;
      dy_q       <= '0;
      config_q   <= '0;
      frame_lo_q <= smsp_pkg::FRAME_LO_RST;
      frame_hi_q <= smsp_pkg::FRAME_HI_RST;
      valid_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      bc_q       <= bc_d;
      addr_q     <= addr_d;
      wshift_q   <= wshift_d;
      last_clk_q <= last_clk_d;
      out_bit_q  <= out_bit_d;
      rumble_q   <= rumble_d;
      pdx_q      <= pdx_d;
      pdy_q      <= pdy_d;
      status_q   <= status_d;
      dx_q       <= dx_d;
      dy_q       <= dy_d;
      config_q   <= config_d;
      frame_lo_q <= frame_lo_d;
      frame_hi_q <= frame_hi_d;
      valid_q    <= valid_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/serial_motion_sensor_port_top.sv */
`default_nettype none
// channel  | dir | tdata bits (low first)                          | tuser
// s_axis   | in  | sclk, sdata, rumble_request, motion_x, motion_y | mode
// m_axis   | out | serial_out, rumble_level                        | -
//
// one request per cycle sustained unless the output stalls; a request waits in the input
// register, and its result is registered into the output register when it fires
// the sensor register file is a one-port-write ram with registered read;
// per-entry valid bits give the power-up values, so no clearing pass
// asynchronous active-low reset clears all control state
// a stalled output holds the input register; s_axis_tready drops only then
module serial_motion_sensor_port_top #(
  parameter int unsigned REGISTER_COUNT = smsp_pkg::REGISTER_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // sclk, sdata, rumble_request, motion_x, motion_y
  input  wire logic        s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata   // serial_out, rumble_level
);

  logic              in_valid_q;
  smsp_pkg::step_t   in_q;
  logic              out_valid_q;
  smsp_pkg::result_t out_q;
  smsp_pkg::result_t res;
  logic              fire;
  logic              s_accept;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q.mode     <= s_axis_tuser;
      in_q.sclk     <= s_axis_tdata[0];
      in_q.sdata    <= s_axis_tdata[1];
      in_q.rumble   <= s_axis_tdata[2];
      in_q.motion_x <= s_axis_tdata[10:3];
      in_q.motion_y <= s_axis_tdata[18:11];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  smsp_core #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (fire),
    .step_i       (in_q),
    .res_o        (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.rumble_level, out_q.serial_out};

`include "serial_motion_sensor_port_top_assert.svh"

  `SMSP_ASSERT_NXT(a_fire_gives_result, clk_i, rst_ni, fire, m_axis_tvalid, "result lost")
  `SMSP_ASSERT_NXT(a_rumble_follows, clk_i, rst_ni, fire && !in_q.mode && !in_q.rumble,
    !m_axis_tdata[1], "rumble level without request")
  `SMSP_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni,
    in_valid_q && out_valid_q && !m_axis_tready, !s_axis_tready, "input taken while stalled")

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import smsp_pkg::*;

  localparam int REG_NUM = REGISTER_COUNT_DEF;
  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] POWERUP [18] = '{
    8'h03, 8'h20, 8'h00, 8'h00, 8'h00, 8'h80, 8'h20, 8'h3F, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h64, 8'h00, 8'h20, 8'hD1
  };

  class motion_port_scoreboard;
    phase_e     phase;
    logic [3:0] bit_count;
    logic [7:0] addr_sr;
    logic [7:0] wr_sr;
    logic       last_clk;
    logic       out_bit;
    logic       rumble;
    logic [7:0] pend_dx;
    logic [7:0] pend_dy;
    logic [7:0] regs [REG_NUM];
    result_t    expected_levels [$];
    int         errors;

    function new();
      for (int i = 0; i < REG_NUM; i++) regs[i] = (i < 18) ? POWERUP[i] : 8'h00;
      clear_session();
      errors = 0;
    endfunction

    function void clear_session();
      pend_dx = 8'h00;
      pend_dy = 8'h00;
      rumble = 1'b0;
      phase = PH_ADDR;
      bit_count = 4'd0;
      addr_sr = 8'h00;
      wr_sr = 8'h00;
      last_clk = 1'b0;
      out_bit = 1'b0;
      regs[REG_STATUS] = 8'h00;
      regs[REG_DX] = 8'h00;
      regs[REG_DY] = 8'h00;
      regs[REG_CONFIG] = 8'h00;
      regs[REG_FRAME_LO] = FRAME_LO_RST;
      regs[REG_FRAME_HI] = FRAME_HI_RST;
    endfunction

    function void advance_sensor(logic clk, logic sd, logic rq);
      logic rise;
      logic low_low;
      rise = !last_clk && clk;
      low_low = !last_clk && !clk;
      rumble = rq;
      case (phase)
        PH_ADDR: begin
          if (rise && bit_count < BYTE_BITS) begin
            addr_sr = {addr_sr[6:0], sd};
            bit_count++;
          end else if (bit_count == BYTE_BITS) begin
            if (addr_sr[7]) begin
              phase = PH_WRITE;
              addr_sr &= ADDR_MASK;
              wr_sr = 8'h00;
            end else begin
              phase = PH_READ;
              if (addr_sr == REG_STATUS) begin
                if (pend_dx != 0 || pend_dy != 0) regs[REG_STATUS] |= MOTION_FLAG;
                regs[REG_DX] = pend_dx;
                regs[REG_DY] = pend_dy;
                pend_dx = 8'h00;
                pend_dy = 8'h00;
              end
            end
            bit_count = 4'd0;
          end
        end
        PH_WRITE: begin
          if (rise && bit_count < BYTE_BITS) begin
            wr_sr = {wr_sr[6:0], sd};
            bit_count++;
          end else if (low_low && bit_count == BYTE_BITS) begin
            phase = PH_ADDR;
            bit_count = 4'd0;
            if (addr_sr < REG_NUM) regs[addr_sr] = wr_sr;
          end
        end
        PH_READ: begin
          if (rise && bit_count < BYTE_BITS) begin
            if (addr_sr < REG_NUM) out_bit = regs[addr_sr][7 - bit_count];
            else out_bit = 1'b0;
            bit_count++;
          end else if (low_low && bit_count == BYTE_BITS) begin
            phase = PH_ADDR;
            bit_count = 4'd0;
            if (addr_sr == REG_STATUS) regs[REG_STATUS] &= ADDR_MASK;
            if (addr_sr == REG_DX || addr_sr == REG_DY) regs[addr_sr] = 8'h00;
          end
        end
        default: ;
      endcase
      last_clk = clk;
      if (regs[REG_CONFIG][7]) clear_session();
    endfunction

    function void note_request(step_t s);
      result_t r;
      if (s.mode) begin
        pend_dx = s.motion_x;
        pend_dy = s.motion_y;
      end else begin
        advance_sensor(s.sclk, s.sdata, s.rumble);
      end
      r.serial_out = out_bit;
      r.rumble_level = rumble;
      expected_levels.push_back(r);
    endfunction

    function void check_result(logic so, logic rl);
      result_t r;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result serial_out=%0b rumble_level=%0b", $time, so, rl);
        errors++;
        return;
      end
      r = expected_levels.pop_front();
      if (so !== r.serial_out) begin
        $display("%0t: serial_out expected %0b actual %0b", $time, r.serial_out, so);
        errors++;
      end
      if (rl !== r.rumble_level) begin
        $display("%0t: rumble_level expected %0b actual %0b", $time, r.rumble_level, rl);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [31:0] cycles = '0;

  motion_port_scoreboard board = new();
  int burst_left = 0;
  int items_sent = 0;
  int motion_mix = 0;
  bit no_gaps = 1'b0;
  bit drained_mid = 1'b0;

  serial_motion_sensor_port_top uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 32'd1;
    case (cycles[11:10])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (cycles[3:0] >= 4'd10);
    endcase
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata[0], m_axis_tdata[1]);
  end

  task automatic send(step_t s);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, s.motion_y, s.motion_x, s.rumble, s.sdata, s.sclk};
    s_axis_tuser <= s.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(s);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_motion(logic [7:0] x, logic [7:0] y);
    step_t s;
    s.mode = 1'b1;
    s.sclk = 1'($urandom_range(0, 1));
    s.sdata = 1'($urandom_range(0, 1));
    s.rumble = 1'($urandom_range(0, 1));
    s.motion_x = x;
    s.motion_y = y;
    send(s);
  endtask

  task automatic send_port(logic clk, logic sd);
    step_t s;
    if ($urandom_range(0, 99) < motion_mix) send_motion(8'($urandom), 8'($urandom));
    s.mode = 1'b0;
    s.sclk = clk;
    s.sdata = sd;
    s.rumble = 1'($urandom_range(0, 1));
    s.motion_x = 8'($urandom);
    s.motion_y = 8'($urandom);
    send(s);
  endtask

  task automatic shift_bits(logic [7:0] b, int count);
    for (int i = 7; i > 7 - count; i--) begin
      send_port(1'b0, b[i]);
      send_port(1'b1, b[i]);
    end
  endtask

  // address byte, a decode step, data byte, then two low clocks to close
  task automatic access_reg(logic [7:0] addr, logic [7:0] data);
    shift_bits(addr, 8);
    send_port(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    shift_bits(addr[7] ? data : 8'($urandom), 8);
    send_port(1'b0, 1'($urandom_range(0, 1)));
    send_port(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.expected_levels.size() != 0);
    burst_left = 0;
  endtask

  initial begin
    logic [7:0] addr;
    int pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    access_reg(8'h00, 8'h00);
    access_reg(REG_FRAME_HI, 8'h00);
    access_reg(8'h7F, 8'h00);
    access_reg(8'h85, 8'hA5);
    access_reg(8'h05, 8'h00);
    access_reg(8'hFF, 8'hFF);
    send_motion(8'h7F, 8'h80);
    access_reg(REG_STATUS, 8'h00);
    access_reg(REG_DX, 8'h00);
    access_reg(REG_DY, 8'h00);
    access_reg(REG_STATUS, 8'h00);
    send_motion(8'hFF, 8'h01);
    access_reg(8'h90, 8'h55);
    access_reg(8'h80 | REG_CONFIG, 8'h80);
    access_reg(REG_FRAME_LO, 8'h00);
    access_reg(REG_STATUS, 8'h00);

    motion_mix = 4;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent % 150 < 40) no_gaps = ($urandom_range(0, 2) == 0);
      if (!drained_mid && items_sent > ITEM_TARGET / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        case ($urandom_range(0, 5))
          0: addr = REG_STATUS;
          1: addr = 8'($urandom_range(REG_DX, REG_DY));
          2, 3: addr = 8'($urandom_range(0, REG_NUM - 1));
          4: addr = 8'($urandom_range(REG_NUM, 127));
          default: addr = 8'($urandom_range(0, 127));
        endcase
        if ($urandom_range(0, 2) == 0) addr[7] = 1'b1;
        access_reg(addr, 8'($urandom));
      end else if (pick < 75) begin
        send_motion(8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6))
          send_port(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        shift_bits(8'($urandom), $urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.expected_levels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
